// File: hw/rtl/assert_macros.svh
// assertion macros for the frame allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define CFA_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frame allocator assertion failed");

// next-cycle implication, sampled on aclk, off during reset
`define CFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frame allocator assertion failed");

`endif

// File: hw/rtl/cfa_pkg.sv
// types, constants and helpers for the contiguous frame allocator
package cfa_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int OWNER_BITS = 8;
    localparam int IDX_BITS   = $clog2(NUM_FRAMES);
    localparam int CNT_BITS   = $clog2(NUM_FRAMES + 1);
    localparam int SUM_BITS   = IDX_BITS + 6;

    localparam int FUNC_W  = 1;
    localparam int OWNER_W = 8;
    localparam int COUNT_W = 5;
    localparam int BASE_W  = 4;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    localparam logic [OWNER_BITS-1:0] FREE_ID = '0;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [OWNER_W-1:0] owner_id;
        logic [COUNT_W-1:0] frame_count;
    } cfa_in_t;

    typedef struct packed {
        logic              status;
        logic [BASE_W-1:0] base_frame;
    } cfa_out_t;

    // per-word strobe into the run scanner
    typedef struct packed {
        logic                clear;
        logic                step;
        logic                free;
        logic [IDX_BITS-1:0] idx;
    } cfa_scan_ctl_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] best_start;
        logic [CNT_BITS-1:0] best_len;
        logic [IDX_BITS-1:0] first_free;
        logic                any_free;
    } cfa_scan_res_t;

    // low OWNER_BITS bits of the requested id
    function automatic logic [OWNER_BITS-1:0] owner_of(input logic [OWNER_W-1:0] id);
        logic [OWNER_BITS+OWNER_W-1:0] wide;
        wide = {{OWNER_BITS{1'b0}}, id};
        return wide[OWNER_BITS-1:0];
    endfunction

    // frame index reported modulo 16
    function automatic logic [BASE_W-1:0] base_of(input logic [IDX_BITS-1:0] idx);
        logic [IDX_BITS+BASE_W-1:0] wide;
        wide = {{BASE_W{1'b0}}, idx};
        return wide[BASE_W-1:0];
    endfunction

endpackage

// File: hw/rtl/cfa_frame_ram.sv
// owner table memory, one read and one write port, entries read as zero until written
module cfa_frame_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_q_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

// File: hw/rtl/cfa_run_scan.sv
// tracks the first free frame and the largest free run over a stream of free flags
module cfa_run_scan (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfa_pkg::cfa_scan_ctl_t ctl,
    output cfa_pkg::cfa_scan_res_t res
);
    import cfa_pkg::*;

    logic [IDX_BITS-1:0] run_start_reg;
    logic [CNT_BITS-1:0] run_len_reg;
    logic [IDX_BITS-1:0] best_start_reg;
    logic [CNT_BITS-1:0] best_len_reg;
    logic [IDX_BITS-1:0] first_free_reg;
    logic                any_free_reg;

    logic [CNT_BITS-1:0] run_len_next;
    logic [IDX_BITS-1:0] run_start_next;

    always_comb begin
        run_len_next   = ctl.free ? run_len_reg + CNT_BITS'(1) : '0;
        run_start_next = (ctl.free && run_len_reg == '0) ? ctl.idx : run_start_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            first_free_reg <= '0;
            any_free_reg   <= 1'b0;
        end else if (ctl.clear) begin
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            first_free_reg <= '0;
            any_free_reg   <= 1'b0;
        end else if (ctl.step) begin
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            // strict compare keeps the lowest run on a tie
            if (run_len_next > best_len_reg) begin
                best_len_reg   <= run_len_next;
                best_start_reg <= run_start_next;
            end
            if (ctl.free && !any_free_reg) begin
                first_free_reg <= ctl.idx;
                any_free_reg   <= 1'b1;
            end
        end
    end

    assign res.best_start = best_start_reg;
    assign res.best_len   = best_len_reg;
    assign res.first_free = first_free_reg;
    assign res.any_free   = any_free_reg;

endmodule

// File: hw/rtl/contiguous_frame_allocator.sv
// contiguous frame allocator top level: request sequencer around the owner table memory
//
//  channel  | ports                         | carries
//  ---------+-------------------------------+-------------------------------------
//  request  | s_valid, s_ready, s_data      | func, owner_id, frame_count
//  result   | m_valid, m_ready, m_data      | status, base_frame
//
// an allocate or free request runs through the states in order:
// a read sweep of the owner table, a decide step, a write-back sweep, then the result is posted
// an allocate that fails skips the write-back sweep
// a request with owner 0 or an allocate of zero frames skips both sweeps and goes straight to posting
// reset clears the table through per-entry valid bits, no clearing pass
// one request is in flight at a time; a new word is taken while the result register waits
module contiguous_frame_allocator (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cfa_pkg::cfa_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cfa_pkg::cfa_out_t m_data
);
    import cfa_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_DONE   = 5'b10000
    } cfa_state_t;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_FRAMES - 1);

    cfa_state_t state_reg, state_next;

    logic [FUNC_W-1:0]     func_reg;
    logic [OWNER_BITS-1:0] who_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [IDX_BITS-1:0]   issue_idx_reg;
    logic                  issue_done_reg;
    logic                  rvalid_reg;
    logic [IDX_BITS-1:0]   ridx_reg;
    logic [NUM_FRAMES-1:0] own_mask_reg;
    logic                  alloc_en_reg;
    logic [SUM_BITS-1:0]   alloc_start_reg;
    logic [SUM_BITS-1:0]   alloc_end_reg;
    logic [IDX_BITS-1:0]   wr_idx_reg;
    cfa_out_t              res_reg;
    logic                  m_valid_reg;
    cfa_out_t              m_data_reg;

    logic                  accept;
    logic [OWNER_BITS-1:0] in_who;
    logic                  early_done;
    logic                  rd_en;
    logic [OWNER_BITS-1:0] rd_data;
    logic                  in_range;
    logic                  wr_en;
    logic [OWNER_BITS-1:0] wr_data;
    logic                  post;
    logic                  cnt_one;
    logic                  fits;
    logic                  found;
    logic [IDX_BITS-1:0]   start_sel;
    cfa_scan_ctl_t         scan_ctl;
    cfa_scan_res_t         scan_res;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign in_who  = owner_of(s_data.owner_id);
    // owner 0, or an allocate of nothing, never touches the table
    assign early_done = (in_who == FREE_ID) ||
                        (s_data.func == FUNC_ALLOC && s_data.frame_count == '0);

    assign rd_en = (state_reg == ST_SCAN) && !issue_done_reg;

    assign scan_ctl.clear = accept;
    assign scan_ctl.step  = rvalid_reg;
    assign scan_ctl.free  = (rd_data == FREE_ID) || (rd_data == who_reg);
    assign scan_ctl.idx   = ridx_reg;

    assign in_range = alloc_en_reg &&
                      (SUM_BITS'(wr_idx_reg) >= alloc_start_reg) &&
                      (SUM_BITS'(wr_idx_reg) < alloc_end_reg);
    assign wr_en   = (state_reg == ST_COMMIT) && (in_range || own_mask_reg[wr_idx_reg]);
    assign wr_data = in_range ? who_reg : FREE_ID;

    assign cnt_one   = (count_reg == COUNT_W'(1));
    assign fits      = {{CNT_BITS{1'b0}}, count_reg} <= {{COUNT_W{1'b0}}, scan_res.best_len};
    assign found     = cnt_one ? scan_res.any_free : fits;
    assign start_sel = cnt_one ? scan_res.first_free : scan_res.best_start;

    assign post = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    cfa_frame_ram #(
        .DEPTH (NUM_FRAMES),
        .WIDTH (OWNER_BITS)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_idx_reg),
        .rd_data (rd_data)
    );

    cfa_run_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (scan_ctl),
        .res     (scan_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = early_done ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rvalid_reg && ridx_reg == LAST_IDX) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (func_reg == FUNC_ALLOC && !found) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (wr_idx_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (post) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            issue_done_reg <= 1'b1;
            rvalid_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rvalid_reg <= rd_en;
            if (accept) begin
                issue_done_reg <= early_done;
            end else if (rd_en && issue_idx_reg == LAST_IDX) begin
                issue_done_reg <= 1'b1;
            end
            if (post) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg      <= s_data.func;
            who_reg       <= in_who;
            count_reg     <= s_data.frame_count;
            issue_idx_reg <= '0;
            own_mask_reg  <= '0;
            wr_idx_reg    <= '0;
            alloc_en_reg  <= 1'b0;
            res_reg.base_frame <= '0;
            res_reg.status <= (s_data.func == FUNC_ALLOC) ? STATUS_FAIL : STATUS_OK;
        end
        if (rd_en) begin
            issue_idx_reg <= issue_idx_reg + IDX_BITS'(1);
        end
        ridx_reg <= issue_idx_reg;
        // frames the owner already holds are released on write-back unless the new run covers them
        if (rvalid_reg && rd_data == who_reg) begin
            own_mask_reg[ridx_reg] <= 1'b1;
        end
        if (state_reg == ST_DECIDE) begin
            alloc_start_reg <= SUM_BITS'(start_sel);
            alloc_end_reg   <= SUM_BITS'(start_sel) + SUM_BITS'(count_reg);
            if (func_reg == FUNC_ALLOC) begin
                alloc_en_reg       <= found;
                res_reg.status     <= found ? STATUS_OK : STATUS_FAIL;
                res_reg.base_frame <= found ? base_of(start_sel) : '0;
            end
        end
        if (state_reg == ST_COMMIT) begin
            wr_idx_reg <= wr_idx_reg + IDX_BITS'(1);
        end
        if (post) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `CFA_ASSERT(a_write_only_in_commit, wr_en, state_reg == ST_COMMIT)
    `CFA_ASSERT(a_read_data_only_in_scan, rvalid_reg, state_reg == ST_SCAN)
    `CFA_ASSERT(a_alloc_writes_owner, wr_en && in_range, wr_data == who_reg && who_reg != FREE_ID)
    `CFA_ASSERT_NEXT(a_post_loads_result, post, m_valid_reg && (state_reg == ST_IDLE))

endmodule

// File: bench/cfa_checker.sv
// checker for the frame allocator: watches both channels, predicts each result and compares
`timescale 1ns / 1ps

module cfa_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  cfa_pkg::cfa_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  cfa_pkg::cfa_out_t m_data,
    output int                errors,
    output int                outstanding,
    output int                checked
);
    import cfa_pkg::*;

    localparam int PRINT_CAP = 50;

    logic [OWNER_BITS-1:0] frame_tab [NUM_FRAMES];
    cfa_out_t              grant_q [$];

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // applies one request to the shadow table and returns the result it should give
    function automatic cfa_out_t predict_grant(input cfa_in_t w);
        cfa_out_t              r;
        logic [OWNER_BITS-1:0] who;
        logic [OWNER_BITS-1:0] view [NUM_FRAMES];
        int                    best_start;
        int                    best_len;
        int                    run_start;
        int                    run_len;
        bit                    found;
        r          = '0;
        r.status   = STATUS_OK;
        who        = w.owner_id[OWNER_BITS-1:0];
        best_start = 0;
        best_len   = 0;
        run_start  = 0;
        run_len    = 0;
        found      = 1'b0;
        if (w.func == FUNC_FREE) begin
            if (who != FREE_ID) begin
                for (int i = 0; i < NUM_FRAMES; i++)
                    if (frame_tab[i] == who) frame_tab[i] = FREE_ID;
            end
            return r;
        end
        if (who == FREE_ID || w.frame_count == 0) begin
            r.status = STATUS_FAIL;
            return r;
        end
        // the owner's old frames count as free while searching
        for (int i = 0; i < NUM_FRAMES; i++)
            view[i] = (frame_tab[i] == who) ? FREE_ID : frame_tab[i];
        if (w.frame_count == 1) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                if (!found && view[i] == FREE_ID) begin
                    best_start = i;
                    found      = 1'b1;
                end
            end
        end else begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                if (view[i] == FREE_ID) begin
                    if (run_len == 0) run_start = i;
                    run_len++;
                end else begin
                    run_len = 0;
                end
                // strict compare keeps the lowest run on a tie
                if (run_len > best_len) begin
                    best_len   = run_len;
                    best_start = run_start;
                end
            end
            found = (best_len > 0) && (int'(w.frame_count) <= best_len);
        end
        if (!found) begin
            r.status = STATUS_FAIL;
            return r;
        end
        for (int i = 0; i < int'(w.frame_count); i++)
            if (best_start + i < NUM_FRAMES) view[best_start + i] = who;
        for (int i = 0; i < NUM_FRAMES; i++)
            frame_tab[i] = view[i];
        r.base_frame = best_start[BASE_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        cfa_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_FRAMES; i++)
                frame_tab[i] = FREE_ID;
            grant_q.delete();
            errors      = 0;
            checked     = 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                checked++;
                if (grant_q.size() == 0) begin
                    report_mismatch($sformatf("result word %0h with nothing expected", m_data));
                end else begin
                    want = grant_q.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status %0b, expected %0b",
                                                  m_data.status, want.status));
                    if (m_data.base_frame !== want.base_frame)
                        report_mismatch($sformatf("base_frame %0d, expected %0d",
                                                  m_data.base_frame, want.base_frame));
                end
            end
            if (s_valid && s_ready)
                grant_q.push_back(predict_grant(s_data));
            outstanding <= grant_q.size();
        end
    end

endmodule

// File: bench/testbench.sv
// top of the frame allocator bench: clock, reset, request and result stimulus, verdict
`timescale 1ns / 1ps

module testbench;
    import cfa_pkg::*;

    localparam int RANDOM_WORDS = 1600;
    localparam int QUIET_FROM   = 1400;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 40;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cfa_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cfa_out_t m_data;

    logic     idle_on    = 1'b0;
    int       stall_left = 0;
    int       errors;
    int       outstanding;
    int       checked;
    int       n_alloc = 0;
    int       n_free  = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    contiguous_frame_allocator u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    cfa_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // result side stalls in bursts, started at random while idle_on is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic cfa_in_t req(input logic [FUNC_W-1:0] f, input logic [OWNER_W-1:0] who,
                                    input logic [COUNT_W-1:0] cnt);
        cfa_in_t w;
        w.func        = f;
        w.owner_id    = who;
        w.frame_count = cnt;
        return w;
    endfunction

    // a few owners that keep coming back, with the odd random or zero id
    function automatic cfa_in_t make_request();
        logic [FUNC_W-1:0]  f;
        logic [OWNER_W-1:0] who;
        logic [COUNT_W-1:0] cnt;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            who = FREE_ID;
        else if (pick < 14)
            who = OWNER_W'($urandom_range(0, 255));
        else
            who = OWNER_W'($urandom_range(1, 6));
        f    = ($urandom_range(0, 3) == 0) ? FUNC_FREE : FUNC_ALLOC;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            cnt = COUNT_W'($urandom_range(0, 31));
        else if (pick < 22)
            cnt = COUNT_W'($urandom_range(7, 16));
        else
            cnt = COUNT_W'($urandom_range(1, 5));
        return req(f, who, cnt);
    endfunction

    // call at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input cfa_in_t w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        if (w.func == FUNC_FREE) n_free++;
        else n_alloc++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        int spins;
        spins = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0 && spins < DRAIN_LIMIT) begin
            @(posedge aclk);
            spins++;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on <= 1'b1;
        @(posedge aclk);

        // zero count, owner zero on both operations
        send_word(req(FUNC_ALLOC, 8'd1, 5'd0));
        send_word(req(FUNC_ALLOC, FREE_ID, 5'd3));
        send_word(req(FUNC_FREE, FREE_ID, 5'd31));
        // whole table, then full-table failures and oversize counts
        send_word(req(FUNC_ALLOC, 8'd1, 5'd16));
        send_word(req(FUNC_ALLOC, 8'd2, 5'd1));
        send_word(req(FUNC_ALLOC, 8'd2, 5'd2));
        send_word(req(FUNC_ALLOC, 8'd1, 5'd17));
        send_word(req(FUNC_ALLOC, 8'd1, 5'd31));
        // owner reallocates over its own frames
        send_word(req(FUNC_ALLOC, 8'd1, 5'd16));
        send_word(req(FUNC_FREE, 8'd1, 5'd0));
        // build a fragmented table, runs that reach the last frame
        send_word(req(FUNC_ALLOC, 8'd255, 5'd1));
        send_word(req(FUNC_ALLOC, 8'd170, 5'd5));
        send_word(req(FUNC_ALLOC, 8'd85, 5'd10));
        send_word(req(FUNC_FREE, 8'd170, 5'd0));
        send_word(req(FUNC_ALLOC, 8'd128, 5'd2));
        send_word(req(FUNC_ALLOC, 8'd85, 5'd12));
        send_word(req(FUNC_ALLOC, 8'd64, 5'd1));
        send_word(req(FUNC_ALLOC, 8'd64, 5'd15));
        send_word(req(FUNC_ALLOC, 8'd170, 5'd8));
        send_word(req(FUNC_FREE, 8'd255, 5'd16));
        send_word(req(FUNC_FREE, 8'd85, 5'd0));
        send_word(req(FUNC_FREE, 8'd128, 5'd0));
        send_word(req(FUNC_FREE, 8'd64, 5'd0));
        send_word(req(FUNC_FREE, 8'd170, 5'd0));
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) drain_results();
            if (n == QUIET_FROM) idle_on <= 1'b0;
            send_word(make_request());
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("summary: %0d requests (%0d allocate, %0d free) sent, %0d results checked",
                 n_alloc + n_free, n_alloc, n_free, checked);
        $display("summary: fragmented tables, full and oversize requests, owner reuse");
        if (errors == 0 && outstanding == 0) begin
            $display("contiguous_frame_allocator verification clean");
        end else begin
            $display("contiguous_frame_allocator verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("contiguous_frame_allocator verification failed");
        $finish;
    end

endmodule
